>>> rtl/framed_record_crc_checker_defines.svh
// assertion macros for the framed record crc checker
// included by rtl/framed_record_crc_checker.sv, no other dependencies
`ifndef FRAMED_RECORD_CRC_CHECKER_DEFINES_SVH
`define FRAMED_RECORD_CRC_CHECKER_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define FRCC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("frcc assertion failed");

// antecedent holds, consequent holds in the next cycle
`define FRCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("frcc assertion failed");

`endif

>>> rtl/frcc_pkg.sv
// types, constants and helper functions for the framed record crc checker
// no dependencies
package frcc_pkg;

    localparam int          COUNT_BITS_DEF = 17;
    localparam int          HDR_BYTES      = 20;
    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;

    localparam logic [15:0] RST_VERSION    = 16'd0;
    localparam logic [31:0] RST_REVISION   = 32'd0;
    localparam logic [15:0] RST_HARD_LIMIT = 16'd4096;
    localparam logic [15:0] RST_PAY_LEN    = 16'd76;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_TOO_LONG  = 4'd2,
        ST_MAGIC     = 4'd3,
        ST_VERSION   = 4'd4,
        ST_SIZE      = 4'd5,
        ST_CRC       = 4'd6,
        ST_REVISION  = 4'd7,
        ST_TRUNCATED = 4'd8,
        ST_TRAILING  = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        REG_VERSION    = 2'd0,
        REG_REVISION   = 2'd1,
        REG_HARD_LIMIT = 2'd2,
        REG_PAY_LEN    = 2'd3
    } reg_idx_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h4C;
            2'd1:    b = 8'h53;
            2'd2:    b = 8'h47;
            default: b = 8'h30;
        endcase
        return b;
    endfunction

    // reflected crc-32, one byte, eight unrolled shift steps
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

>>> rtl/framed_record_crc_checker.sv
// framed record checker: 20-byte header, crc-32 over payload, one status per record
// input transaction to result on m_tvalid: through input register, then result register
// throughput: one byte per cycle unless a last byte waits; header capture and unrolled crc
// byte step in one stage; a status waiting in the result register stalls only a last byte
// reset: aresetn sync active low, clears handshake state, record state and config registers
// depends on frcc_pkg and framed_record_crc_checker_defines.svh
`include "framed_record_crc_checker_defines.svh"

module framed_record_crc_checker #(
    parameter int COUNT_BITS = frcc_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [3:0] status, [35:4] record_flags, [39:36] zero
);
    import frcc_pkg::*;

    localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] HDR_CNT   = COUNT_BITS'(HDR_BYTES);

    // configuration registers
    logic [15:0] exp_version_reg;
    logic [31:0] exp_revision_reg;
    logic [15:0] hard_limit_reg;
    logic [15:0] pay_len_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // record state
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic        magic_bad_reg, magic_bad_next;
    logic [15:0] hdr_version_reg, hdr_version_next;
    logic [15:0] hdr_size_reg, hdr_size_next;
    logic [31:0] hdr_revision_reg, hdr_revision_next;
    logic [31:0] hdr_flags_reg, hdr_flags_next;
    logic [31:0] hdr_crc_reg, hdr_crc_next;
    logic [31:0] crc_reg, crc_next;

    // result register
    logic        m_valid_reg;
    status_t     m_status_reg, status_next;
    logic [31:0] m_flags_reg;

    logic        adv;
    logic [4:0]  pos;
    logic        cfg_wr;
    logic [CMP_W-1:0] total_w, limit_w, size_w, need_w;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_version_reg  <= RST_VERSION;
            exp_revision_reg <= RST_REVISION;
            hard_limit_reg   <= RST_HARD_LIMIT;
            pay_len_reg      <= RST_PAY_LEN;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_VERSION:    exp_version_reg  <= pwdata[15:0];
                REG_REVISION:   exp_revision_reg <= pwdata;
                REG_HARD_LIMIT: hard_limit_reg   <= pwdata[15:0];
                REG_PAY_LEN:    pay_len_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_VERSION:    prdata = {16'd0, exp_version_reg};
            REG_REVISION:   prdata = exp_revision_reg;
            REG_HARD_LIMIT: prdata = {16'd0, hard_limit_reg};
            REG_PAY_LEN:    prdata = {16'd0, pay_len_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // a last byte only moves on when the result register is free or draining
    assign adv      = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // header capture, crc step and count
    assign pos = count_reg[4:0];

    always_comb begin
        magic_bad_next    = magic_bad_reg;
        hdr_version_next  = hdr_version_reg;
        hdr_size_next     = hdr_size_reg;
        hdr_revision_next = hdr_revision_reg;
        hdr_flags_next    = hdr_flags_reg;
        hdr_crc_next      = hdr_crc_reg;
        crc_next          = crc_reg;
        if (count_reg < HDR_CNT) begin
            if (pos < 5'd4) begin
                if (in_byte_reg != magic_byte(pos[1:0])) magic_bad_next = 1'b1;
            end else if (pos < 5'd6) begin
                hdr_version_next[{pos[0], 3'b000} +: 8] = in_byte_reg;
            end else if (pos < 5'd8) begin
                hdr_size_next[{pos[0], 3'b000} +: 8] = in_byte_reg;
            end else if (pos < 5'd12) begin
                hdr_revision_next[{pos[1:0], 3'b000} +: 8] = in_byte_reg;
            end else if (pos < 5'd16) begin
                hdr_flags_next[{pos[1:0], 3'b000} +: 8] = in_byte_reg;
            end else begin
                hdr_crc_next[{pos[1:0], 3'b000} +: 8] = in_byte_reg;
            end
        end else begin
            crc_next = crc_byte(crc_reg, in_byte_reg);
        end
        count_next = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    end

    // checks in priority order on the updated record state
    always_comb begin
        total_w = CMP_W'(count_next);
        limit_w = CMP_W'(hard_limit_reg);
        size_w  = CMP_W'(hdr_size_next);
        need_w  = CMP_W'(pay_len_reg) + CMP_W'(HDR_BYTES);
        if (total_w < CMP_W'(HDR_BYTES))                  status_next = ST_SHORT;
        else if (count_next == COUNT_MAX || total_w > limit_w) status_next = ST_TOO_LONG;
        else if (magic_bad_next)                          status_next = ST_MAGIC;
        else if (hdr_version_next != exp_version_reg)     status_next = ST_VERSION;
        else if (size_w != total_w)                       status_next = ST_SIZE;
        else if ((crc_next ^ CRC_INIT) != hdr_crc_next)   status_next = ST_CRC;
        else if (hdr_revision_next != exp_revision_reg)   status_next = ST_REVISION;
        else if (total_w < need_w)                        status_next = ST_TRUNCATED;
        else if (total_w > need_w)                        status_next = ST_TRAILING;
        else                                              status_next = ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (adv && in_last_reg)) begin
            count_reg        <= '0;
            magic_bad_reg    <= 1'b0;
            hdr_version_reg  <= '0;
            hdr_size_reg     <= '0;
            hdr_revision_reg <= '0;
            hdr_flags_reg    <= '0;
            hdr_crc_reg      <= '0;
            crc_reg          <= CRC_INIT;
        end else if (adv) begin
            count_reg        <= count_next;
            magic_bad_reg    <= magic_bad_next;
            hdr_version_reg  <= hdr_version_next;
            hdr_size_reg     <= hdr_size_next;
            hdr_revision_reg <= hdr_revision_next;
            hdr_flags_reg    <= hdr_flags_next;
            hdr_crc_reg      <= hdr_crc_next;
            crc_reg          <= crc_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_last_reg) begin
            m_status_reg <= status_next;
            m_flags_reg  <= (status_next == ST_OK) ? hdr_flags_next : 32'd0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_flags_reg, m_status_reg};

    `FRCC_ASSERT_SAME(a_flags_zero_on_fail, aclk, aresetn,
        m_valid_reg && (m_status_reg != ST_OK), m_flags_reg == 32'd0)
    `FRCC_ASSERT_SAME(a_status_in_range, aclk, aresetn,
        m_valid_reg, m_status_reg <= ST_TRAILING)
    `FRCC_ASSERT_NEXT(a_record_cleared, aclk, aresetn,
        adv && in_last_reg, (count_reg == '0) && (crc_reg == CRC_INIT) && m_valid_reg)

endmodule
